/* rtl/hamming_31_26_frame_encoder_core_macros.svh */
// Assertion macros for the Hamming(31,26) frame encoder.
// Included by the modules that carry concurrent checks; depends on nothing.
`ifndef HAMMING_31_26_FRAME_ENCODER_CORE_MACROS_SVH
`define HAMMING_31_26_FRAME_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HMFE_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("hamming frame encoder check failed");

// Next-cycle implication, disabled during reset.
`define HMFE_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("hamming frame encoder check failed");

`endif

/* rtl/hmfe_pkg.sv */
// Shared types, constants and helpers for the Hamming(31,26) frame encoder.
// Used by the frame store, the serial chunk encoder and the top level.
package hmfe_pkg;

  localparam int BYTE_W         = 8;
  localparam int FRAME_BYTES    = 26;
  localparam int CODE_BYTES     = 31;
  localparam int CHUNK_DATA     = 26;
  localparam int CHUNK_CODE     = 31;
  localparam int CHUNKS         = 8;
  localparam int ADDR_W         = $clog2(FRAME_BYTES);
  localparam int POS_W          = $clog2(CHUNK_CODE + 1);
  localparam int PAR_W          = 5;
  localparam int CHUNK_W        = $clog2(CHUNKS);
  localparam int BIT_W          = $clog2(BYTE_W);
  localparam int OBYTE_W        = $clog2(CODE_BYTES);
  localparam int FIRST_DATA_POS = 3;

  typedef enum logic [1:0] {
    ST_RECV,
    ST_START,
    ST_GATHER,
    ST_EMIT
  } state_t;

  // Control from the sequencer to the chunk encoder.
  typedef struct packed {
    logic clr;
    logic din_en;
    logic din;
    logic dout_en;
  } enc_ctrl_t;

  function automatic logic is_pow2(input logic [POS_W-1:0] p);
    return (p != '0) && ((p & (p - POS_W'(1))) == '0);
  endfunction

  // Parity bit index for a power-of-two code position.
  function automatic logic [2:0] par_idx(input logic [POS_W-1:0] p);
    logic [2:0] idx;
    idx = '0;
    for (int i = 0; i < PAR_W; i++) begin
      if (p[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  // Next code position that carries data.
  function automatic logic [POS_W-1:0] next_data_pos(input logic [POS_W-1:0] p);
    logic [POS_W-1:0] n;
    n = p + POS_W'(1);
    if (is_pow2(n)) n = n + POS_W'(1);
    return n;
  endfunction

endpackage

/* rtl/hmfe_store.sv */
// Frame store: one write port, one registered read port, one byte per entry.
// Depends on hmfe_pkg for the frame geometry.
module hmfe_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [hmfe_pkg::ADDR_W-1:0] wr_addr,
  input  logic [hmfe_pkg::BYTE_W-1:0] wr_data,
  input  logic [hmfe_pkg::ADDR_W-1:0] rd_addr,
  output logic [hmfe_pkg::BYTE_W-1:0] rd_data
);
  import hmfe_pkg::*;

  logic [BYTE_W-1:0] mem [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/hmfe_chunk_enc.sv */
// Bit-serial Hamming(31,26) chunk encoder: takes 26 data bits, then emits
// 31 code bits by position. Depends on hmfe_pkg for enc_ctrl_t and helpers.
module hmfe_chunk_enc (
  input  logic                       clk,
  input  hmfe_pkg::enc_ctrl_t        ctrl,
  input  logic [hmfe_pkg::POS_W-1:0] pos,
  output logic                       dout
);
  import hmfe_pkg::*;

  logic [CHUNK_DATA-1:0] data_sr;
  logic [PAR_W-1:0]      par;

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      par <= '0;
    end else if (ctrl.din_en) begin
      // each data bit toggles the parity bits named by its position
      par     <= par ^ (ctrl.din ? pos : '0);
      data_sr <= {data_sr[CHUNK_DATA-2:0], ctrl.din};
    end else if (ctrl.dout_en && !is_pow2(pos)) begin
      data_sr <= {data_sr[CHUNK_DATA-2:0], 1'b0};
    end
  end

  assign dout = is_pow2(pos) ? par[par_idx(pos)] : data_sr[CHUNK_DATA-1];

endmodule

/* rtl/hamming_31_26_frame_encoder_core.sv */
// Top level of the Hamming(31,26) frame encoder.
// Depends on hmfe_pkg, hmfe_store, hmfe_chunk_enc and the assertion macros.
`include "hamming_31_26_frame_encoder_core_macros.svh"

// Collects bytes into 26-byte frames and emits each full frame as 31 bytes
// of eight Hamming(31,26) codewords, MSB first, m_axis_tlast on the last.
// A byte with s_axis_tlast that does not complete a frame drops the frame.
// Input bytes are taken one per cycle while a frame is being collected. Once
// the 26th byte arrives, encoding runs bit-serially through one shared chunk
// encoder: a start state, then per chunk a gather phase for the data bits
// and an emit phase for the code bits, which stalls before a byte's last bit
// while the output register still holds an untaken byte. No input is taken
// during encoding. A finished byte waits in the output register while the
// encoder keeps working on the next one.
module hamming_31_26_frame_encoder_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [hmfe_pkg::BYTE_W-1:0] s_axis_tdata,  // [7:0] data_byte
  input  logic                       s_axis_tlast,  // end_of_file
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [hmfe_pkg::BYTE_W-1:0] m_axis_tdata,  // [7:0] code_byte
  output logic                       m_axis_tlast   // frame_done
);
  import hmfe_pkg::*;

  state_t              state, state_next;
  logic [ADDR_W-1:0]   count;
  logic [ADDR_W-1:0]   rd_addr;
  logic [BYTE_W-1:0]   rd_data;
  logic [BYTE_W-1:0]   byte_sr;
  logic [BIT_W-1:0]    bit_cnt;
  logic [POS_W-1:0]    pos;
  logic [CHUNK_W-1:0]  chunk;
  logic [BYTE_W-2:0]   out_sr;
  logic [BIT_W-1:0]    out_cnt;
  logic [OBYTE_W-1:0]  byte_idx;
  enc_ctrl_t           ctrl;
  logic                enc_bit;
  logic                in_xfer;
  logic                gather_bit;
  logic                emit_ok;
  logic                emit_step;
  logic                out_load;
  logic                chunk_end;

  hmfe_store u_store (
    .clk     (clk),
    .wr_en   (in_xfer),
    .wr_addr (count),
    .wr_data (s_axis_tdata),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hmfe_chunk_enc u_enc (
    .clk  (clk),
    .ctrl (ctrl),
    .pos  (pos),
    .dout (enc_bit)
  );

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign gather_bit = (bit_cnt == '0) ? rd_data[BYTE_W-1] : byte_sr[BYTE_W-1];
  assign emit_ok    = (out_cnt != BIT_W'(BYTE_W - 1)) || !m_axis_tvalid || m_axis_tready;
  assign chunk_end  = (pos == POS_W'(CHUNK_CODE));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_RECV: begin
        if (in_xfer && count == ADDR_W'(FRAME_BYTES - 1)) state_next = ST_START;
      end
      ST_START: begin
        state_next = ST_GATHER;
      end
      ST_GATHER: begin
        if (chunk_end) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ok && chunk_end) begin
          state_next = (chunk == CHUNK_W'(CHUNKS - 1)) ? ST_RECV : ST_GATHER;
        end
      end
      default: state_next = ST_RECV;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    emit_step     = 1'b0;
    ctrl          = '0;
    unique case (state)
      ST_RECV: begin
        s_axis_tready = 1'b1;
      end
      ST_START: begin
        ctrl.clr = 1'b1;
      end
      ST_GATHER: begin
        ctrl.din_en = 1'b1;
        ctrl.din    = gather_bit;
      end
      ST_EMIT: begin
        emit_step    = emit_ok;
        ctrl.dout_en = emit_ok;
        ctrl.clr     = emit_ok && chunk_end && (chunk != CHUNK_W'(CHUNKS - 1));
      end
      default: ;
    endcase
  end

  assign out_load = emit_step && (out_cnt == BIT_W'(BYTE_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RECV;
      count         <= '0;
      rd_addr       <= '0;
      bit_cnt       <= '0;
      pos           <= POS_W'(FIRST_DATA_POS);
      chunk         <= '0;
      out_cnt       <= '0;
      byte_idx      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;

      if (in_xfer) begin
        if (count == ADDR_W'(FRAME_BYTES - 1) || s_axis_tlast) begin
          count <= '0;
        end else begin
          count <= count + ADDR_W'(1);
        end
        rd_addr <= '0;
      end

      if (state == ST_START) begin
        pos <= POS_W'(FIRST_DATA_POS);
      end

      if (state == ST_GATHER) begin
        if (bit_cnt == '0) begin
          bit_cnt <= BIT_W'(BYTE_W - 1);
          if (rd_addr != ADDR_W'(FRAME_BYTES - 1)) rd_addr <= rd_addr + ADDR_W'(1);
        end else begin
          bit_cnt <= bit_cnt - BIT_W'(1);
        end
        pos <= chunk_end ? POS_W'(1) : next_data_pos(pos);
      end

      if (emit_step) begin
        out_cnt <= out_cnt + BIT_W'(1);
        if (chunk_end) begin
          pos   <= POS_W'(FIRST_DATA_POS);
          chunk <= chunk + CHUNK_W'(1);
        end else begin
          pos <= pos + POS_W'(1);
        end
      end

      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        byte_idx      <= (byte_idx == OBYTE_W'(CODE_BYTES - 1)) ? '0
                                                                : byte_idx + OBYTE_W'(1);
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_GATHER) begin
      byte_sr <= (bit_cnt == '0) ? {rd_data[BYTE_W-2:0], 1'b0}
                                 : {byte_sr[BYTE_W-2:0], 1'b0};
    end
    if (emit_step) begin
      out_sr <= {out_sr[BYTE_W-3:0], enc_bit};
    end
    if (out_load) begin
      m_axis_tdata <= {out_sr, enc_bit};
      m_axis_tlast <= (byte_idx == OBYTE_W'(CODE_BYTES - 1));
    end
  end

  // a finished byte never overwrites one that has not been transferred
  `HMFE_ASSERT_NOW(a_no_overwrite, clk, rst, out_load, !m_axis_tvalid || m_axis_tready)

  // the last code bit of the last chunk closes the 31st byte
  `HMFE_ASSERT_NOW(a_frame_close, clk, rst,
    state == ST_EMIT && emit_step && chunk_end && chunk == CHUNK_W'(CHUNKS - 1),
    out_load && byte_idx == OBYTE_W'(CODE_BYTES - 1))

  // the last chunk of a frame ends on a byte boundary and returns to collection with all counters at zero
  `HMFE_ASSERT_NEXT(a_frame_idle, clk, rst,
    state == ST_EMIT && emit_step && chunk_end && chunk == CHUNK_W'(CHUNKS - 1),
    state == ST_RECV && byte_idx == '0 && out_cnt == '0 && bit_cnt == '0)

  // input is taken only while collecting
  `HMFE_ASSERT_NOW(a_recv_only, clk, rst, s_axis_tready, state == ST_RECV)

endmodule
